// File: src/i2cms_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
`timescale 1ns / 1ps

package i2cms_pkg;

    // Command codes carried on the request channel
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_STOP  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam int PHASE_W = 16;
    localparam logic [PHASE_W-1:0] PHASE_CYCLES_RESET = 16'd250;

    // Phase index layout
    localparam int IDX_W = 5;
    localparam logic [IDX_W-1:0] WR_DATA_PHASES = 5'd24;  // 8 bits x 3 phases
    localparam logic [IDX_W-1:0] WR_ACK_CLK     = 5'd24;
    localparam logic [IDX_W-1:0] RD_DATA_PHASES = 5'd16;  // 8 bits x 2 phases
    localparam logic [IDX_W-1:0] RD_ACK_SET     = 5'd16;
    localparam logic [IDX_W-1:0] RD_ACK_CLK     = 5'd17;
    localparam logic [IDX_W-1:0] RD_ACK_END     = 5'd18;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture a new command request
        logic tick;     // count down the phase hold timer
        logic advance;  // step to the next phase and reload the timer
        logic emit;     // current phase request taken downstream
    } i2cms_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hold_done;
        logic last_phase;
    } i2cms_status_t;

endpackage

// File: src/i2cms_ctrl.sv
// Controller state machine: request intake, phase hold and phase handoff.
`timescale 1ns / 1ps

module i2cms_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  i2cms_pkg::i2cms_status_t status,
    output i2cms_pkg::i2cms_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_HOLD = 3'b010,
        ST_SEND = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                cmd.tick = 1'b1;
                if (status.hold_done) begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.emit = 1'b1;
                    if (status.last_phase) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.advance = 1'b1;
                        state_next  = ST_HOLD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/i2cms_datapath.sv
// Datapath: command registers, phase counters, hold timer and phase decode.
`timescale 1ns / 1ps

module i2cms_datapath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  i2cms_pkg::i2cms_cmd_t    cmd,
    output i2cms_pkg::i2cms_status_t status,
    input  logic                     cfg_wr_en,
    input  logic [15:0]              cfg_wr_data,
    input  logic [1:0]               in_kind,
    input  logic [7:0]               in_tx_byte,
    input  logic                     in_master_ack,
    input  logic [7:0]               in_slave_byte,
    input  logic                     in_slave_ack_bit,
    output logic                     out_scl,
    output logic                     out_sda,
    output logic [7:0]               out_rx_byte,
    output logic                     out_ack_seen,
    output logic                     out_last
);

    logic [i2cms_pkg::PHASE_W-1:0] phase_cycles_reg;
    logic [i2cms_pkg::PHASE_W-1:0] hold_cnt_reg;
    logic [i2cms_pkg::IDX_W-1:0]   idx_reg;
    logic [1:0]                    sub_reg;
    logic [1:0]                    kind_reg;
    logic [7:0]                    shift_reg;
    logic [7:0]                    slave_byte_reg;
    logic                          master_ack_reg;
    logic                          slave_ack_reg;
    logic                          sda_level_reg;
    logic                          sub_wrap;

    // Phase length register; a written zero is taken as one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_cycles_reg <= i2cms_pkg::PHASE_CYCLES_RESET;
        end else if (cfg_wr_en) begin
            phase_cycles_reg <= (cfg_wr_data == '0) ? 16'd1 : cfg_wr_data;
        end
    end

    // Bus data level left by the last emitted phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sda_level_reg <= 1'b1;
        end else if (cmd.emit) begin
            sda_level_reg <= out_sda;
        end
    end

    // Sub-phase wraps after 3 phases per written bit, 2 per read bit
    assign sub_wrap = (kind_reg == i2cms_pkg::KIND_WRITE) ? (sub_reg == 2'd2)
                                                          : (sub_reg == 2'd1);

    // Command capture, phase counters and hold timer
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg       <= in_kind;
            shift_reg      <= in_tx_byte;
            master_ack_reg <= in_master_ack;
            slave_byte_reg <= in_slave_byte;
            slave_ack_reg  <= in_slave_ack_bit;
            idx_reg        <= '0;
            sub_reg        <= '0;
            hold_cnt_reg   <= phase_cycles_reg;
        end else if (cmd.advance) begin
            idx_reg      <= idx_reg + 1'b1;
            hold_cnt_reg <= phase_cycles_reg;
            if (sub_wrap) begin
                sub_reg   <= '0;
                shift_reg <= {shift_reg[6:0], 1'b0};
            end else begin
                sub_reg <= sub_reg + 1'b1;
            end
        end else if (cmd.tick) begin
            hold_cnt_reg <= hold_cnt_reg - 1'b1;
        end
    end

    assign status.hold_done  = (hold_cnt_reg == 16'd1);
    assign status.last_phase = out_last;

    // Phase decode: line levels and result fields for the current phase
    always_comb begin
        out_scl      = 1'b1;
        out_sda      = 1'b1;
        out_rx_byte  = 8'd0;
        out_ack_seen = 1'b0;
        out_last     = 1'b0;
        case (kind_reg)
            i2cms_pkg::KIND_START: begin
                if (idx_reg == 5'd1) begin
                    out_sda = 1'b0;
                end else if (idx_reg != 5'd0) begin
                    out_scl  = 1'b0;
                    out_sda  = 1'b0;
                    out_last = 1'b1;
                end
            end
            i2cms_pkg::KIND_STOP: begin
                if (idx_reg == 5'd0) begin
                    out_sda = sda_level_reg;
                end else begin
                    out_last = 1'b1;
                end
            end
            i2cms_pkg::KIND_WRITE: begin
                if (idx_reg < i2cms_pkg::WR_DATA_PHASES) begin
                    // data set with clock high, clock low, data low
                    out_scl = (sub_reg == 2'd0);
                    out_sda = (sub_reg == 2'd2) ? 1'b0 : shift_reg[7];
                end else if (idx_reg != i2cms_pkg::WR_ACK_CLK) begin
                    out_scl      = 1'b0;
                    out_ack_seen = ~slave_ack_reg;
                    out_last     = 1'b1;
                end
            end
            i2cms_pkg::KIND_READ: begin
                if (idx_reg < i2cms_pkg::RD_DATA_PHASES) begin
                    out_scl = (sub_reg == 2'd0);
                end else if (idx_reg == i2cms_pkg::RD_ACK_SET) begin
                    out_sda = ~master_ack_reg;
                end else if (idx_reg == i2cms_pkg::RD_ACK_CLK) begin
                    out_scl = 1'b0;
                    out_sda = ~master_ack_reg;
                end else if (idx_reg == i2cms_pkg::RD_ACK_END) begin
                    out_scl = 1'b0;
                    out_sda = 1'b0;
                end else begin
                    // the result byte is the slave byte captured with the command, not shifted in
                    out_scl     = 1'b0;
                    out_sda     = 1'b0;
                    out_rx_byte = slave_byte_reg;
                    out_last    = 1'b1;
                end
            end
            default: begin
                out_last = 1'b1;
            end
        endcase
    end

endmodule

// File: src/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer.
`timescale 1ns / 1ps

// One command request (start, stop, write byte, read byte) turns into a run of
// bus phase requests, one per phase, each giving the SCL and SDA levels
// (1 = released). Start gives 3 phases, stop 2, write 26, read 20. Each phase
// is held in the hold timer, which counts down from phase_cycles (a write of 0
// counts as 1), and is then offered on the m_ side; the next phase starts its
// hold when that request is taken, so a downstream stall holds up the command.
// The hold timer sets the pace, and one command is in flight at a time.
// Configuration is to be written through cfg_wr_en/cfg_wr_data only while
// idle; the block itself does not enforce it.
module i2c_master_bit_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // phase_cycles
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // tx_byte[7:0], master_ack, slave_byte[7:0],
                                       // slave_ack_bit, zero pad
    input  logic [1:0]  s_tuser,       // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // scl, sda, rx_byte[7:0], ack_seen, zero pad
    output logic        m_tlast        // last phase of the command
);

    i2cms_pkg::i2cms_cmd_t    cmd;
    i2cms_pkg::i2cms_status_t status;
    logic                     scl;
    logic                     sda;
    logic [7:0]               rx_byte;
    logic                     ack_seen;

    i2cms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    i2cms_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_kind          (s_tuser),
        .in_tx_byte       (s_tdata[7:0]),
        .in_master_ack    (s_tdata[8]),
        .in_slave_byte    (s_tdata[16:9]),
        .in_slave_ack_bit (s_tdata[17]),
        .out_scl          (scl),
        .out_sda          (sda),
        .out_rx_byte      (rx_byte),
        .out_ack_seen     (ack_seen),
        .out_last         (m_tlast)
    );

    assign m_tdata = {5'd0, ack_seen, rx_byte, sda, scl};

    // One command in flight: no intake while a phase is offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("command intake while a phase is pending");

    // A taken phase that is not last is followed by a hold, not a new intake
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (!m_tvalid && !s_tready))
        else $error("phase hold skipped");

    // The last phase taken returns the block to command intake
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not ready after final phase");

    // A taken command is never answered in the very next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!m_tvalid && !s_tready))
        else $error("phase offered without hold");

endmodule
